FILE: src/teg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// teg_pkg
// Shared types and constants of the thermal erosion heightmap block.
// ----------------------------------------------------------------------------
package teg_pkg;

    localparam int unsigned HEIGHT_W  = 24;
    localparam int unsigned MOB_W     = 9;
    localparam int unsigned RATE_W    = 17;
    localparam int unsigned FRAC_BITS = 26;
    localparam int unsigned ACC_W     = 53;
    localparam int unsigned PROD1_W   = HEIGHT_W + RATE_W;
    localparam int unsigned PROD2_W   = PROD1_W + MOB_W - 1;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 24'd10240000;
    localparam logic [MOB_W-1:0]    MOB_ONE    = 9'd256;
    localparam logic [RATE_W-1:0]   RATE_ONE   = 17'd65536;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_WRITE = 2'd0;
    localparam t_cmd CMD_RUN   = 2'd1;
    localparam t_cmd CMD_READ  = 2'd2;
    localparam t_cmd CMD_NOP   = 2'd3;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_GRID_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_GRID_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_SWEEP_COUNT = 3'd2;
    localparam t_cfg_idx CFG_RATE        = 3'd3;
    localparam t_cfg_idx CFG_TALUS       = 3'd4;
    localparam t_cfg_idx CFG_WRAP        = 3'd5;

endpackage
`default_nettype wire

FILE: src/teg_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// teg_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module teg_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/thermal_erosion_grid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thermal_erosion_grid
// Heightmap store with write, read and double-buffered thermal erosion runs.
// ----------------------------------------------------------------------------
// Each item is one command. A write of a cell replies directly; a read passes
// through the S_READ state first. A run command sweeps every stored cell
// (MAX_COLS * MAX_ROWS of them) once per configured sweep; for each cell the
// centre and its four neighbours are read one after another through the single
// read port of the current height bank, followed by a three-stage
// multiply-accumulate drain. Heights live in two banks that swap roles after
// every sweep; mobility lives in a third memory. One item is in work at a time,
// and the reply waits in an output register; the next command is taken only
// once that register is empty or its reply transfers in the same cycle.
// ----------------------------------------------------------------------------
module thermal_erosion_grid #(
    parameter int unsigned MAX_COLS = 64,
    parameter int unsigned MAX_ROWS = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration write port
    input  wire logic                         i_cfg_we,
    input  wire teg_pkg::t_cfg_idx            i_cfg_index,
    input  wire logic [23:0]                  i_cfg_data,
    // command channel
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire teg_pkg::t_cmd                i_cmd,
    input  wire logic [5:0]                   i_cell_x,
    input  wire logic [5:0]                   i_cell_y,
    input  wire logic [23:0]                  i_height_in,
    input  wire logic [8:0]                   i_mobility_in,
    // reply channel
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output teg_pkg::t_cmd                     o_reply_kind,
    output logic [23:0]                       o_height_out
);
    import teg_pkg::*;

    localparam int unsigned CW    = $clog2(MAX_COLS);
    localparam int unsigned RW    = $clog2(MAX_ROWS);
    localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
    localparam int unsigned AW    = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;

    localparam logic [3:0] PH_LAST = 4'd8;

    // configuration
    logic [6:0]          r_grid_width;
    logic [6:0]          r_grid_height;
    logic [15:0]         r_sweep_count;
    logic [RATE_W-1:0]   r_rate;
    logic [HEIGHT_W-1:0] r_talus;
    logic                r_wrap;

    // control
    logic [1:0]  r_state;
    logic        r_bank;
    logic [15:0] r_sweeps_left;
    logic [3:0]  r_phase;
    logic [CW-1:0] r_x;
    logic [RW-1:0] r_y;
    logic        r_rd_inside;

    // read pipeline
    logic        r_rvalid;
    logic [3:0]  r_rtag;
    logic [HEIGHT_W-1:0] r_ch;
    logic [MOB_W-1:0]    r_cm;
    logic        r_v1, r_neg1, r_v2, r_neg2;
    logic [PROD1_W-1:0]  r_p1;
    logic [MOB_W-1:0]    r_m1;
    logic [PROD2_W-1:0]  r_p2;
    logic signed [ACC_W-1:0] r_acc;

    // reply register
    logic          r_out_valid;
    t_cmd          r_out_kind;
    logic [23:0]   r_out_height;

    // clamped grid size and rate
    logic [CW:0] wc;
    logic [RW:0] hc;
    logic [RATE_W-1:0] rate_c;

    always_comb begin
        if (r_grid_width == 7'd0) begin
            wc = (CW+1)'(1);
        end else if (32'(r_grid_width) > MAX_COLS) begin
            wc = (CW+1)'(MAX_COLS);
        end else begin
            wc = (CW+1)'(r_grid_width);
        end
        if (r_grid_height == 7'd0) begin
            hc = (RW+1)'(1);
        end else if (32'(r_grid_height) > MAX_ROWS) begin
            hc = (RW+1)'(MAX_ROWS);
        end else begin
            hc = (RW+1)'(r_grid_height);
        end
        rate_c = (r_rate > RATE_ONE) ? RATE_ONE : r_rate;
    end

    // command side
    logic accept;
    logic in_inside;
    logic [AW-1:0] in_addr;
    assign accept    = i_valid && !o_stall;
    assign o_stall   = !((r_state == S_IDLE) && (!r_out_valid || !i_stall));
    assign in_inside = (32'(i_cell_x) < 32'(wc)) && (32'(i_cell_y) < 32'(hc));
    assign in_addr   = AW'(i_cell_y) * AW'(MAX_COLS) + AW'(i_cell_x);

    // sweep cell and neighbour addressing
    logic cell_in;
    logic [CW-1:0] nx;
    logic [RW-1:0] ny;
    logic [AW-1:0] cell_addr, sw_raddr;
    assign cell_in   = ((CW+1)'(r_x) < wc) && ((RW+1)'(r_y) < hc);
    assign cell_addr = AW'(r_y) * AW'(MAX_COLS) + AW'(r_x);

    always_comb begin
        nx = r_x;
        ny = r_y;
        case (r_phase)
            4'd1: begin
                if (r_x != '0) nx = r_x - 1'b1;
                else if (r_wrap) nx = CW'(wc - 1'b1);
            end
            4'd2: begin
                if ((CW+1)'(r_x) + 1'b1 < wc) nx = r_x + 1'b1;
                else if (r_wrap) nx = '0;
            end
            4'd3: begin
                if (r_y != '0) ny = r_y - 1'b1;
                else if (r_wrap) ny = RW'(hc - 1'b1);
            end
            4'd4: begin
                if ((RW+1)'(r_y) + 1'b1 < hc) ny = r_y + 1'b1;
                else if (r_wrap) ny = '0;
            end
            default: begin
                nx = r_x;
                ny = r_y;
            end
        endcase
        sw_raddr = AW'(ny) * AW'(MAX_COLS) + AW'(nx);
    end

    // memories
    logic [AW-1:0] raddr;
    logic [HEIGHT_W-1:0] h_a, h_b, h_rd, h_wdata, h_new;
    logic [MOB_W-1:0]    m_rd, m_wdata;
    logic we_cmd, we_sweep, we_a, we_b;
    logic [AW-1:0] waddr;
    logic r_rbank;

    assign raddr    = (r_state == S_SWEEP) ? sw_raddr : in_addr;
    assign we_cmd   = accept && (i_cmd == CMD_WRITE) && in_inside;
    assign we_sweep = (r_state == S_SWEEP) && (r_phase == PH_LAST);
    assign waddr    = we_sweep ? cell_addr : in_addr;
    assign h_wdata  = we_sweep ? h_new :
                      ((i_height_in > HEIGHT_MAX) ? HEIGHT_MAX : i_height_in);
    assign m_wdata  = (i_mobility_in > MOB_ONE) ? MOB_ONE : i_mobility_in;
    assign we_a     = (we_cmd && !r_bank) || (we_sweep && r_bank);
    assign we_b     = (we_cmd && r_bank) || (we_sweep && !r_bank);
    assign h_rd     = r_rbank ? h_b : h_a;

    teg_ram #(.WIDTH(HEIGHT_W), .DEPTH(DEPTH)) u_bank_a (
        .i_clk(i_clk), .i_we(we_a), .i_waddr(waddr), .i_wdata(h_wdata),
        .i_raddr(raddr), .o_rdata(h_a)
    );
    teg_ram #(.WIDTH(HEIGHT_W), .DEPTH(DEPTH)) u_bank_b (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(waddr), .i_wdata(h_wdata),
        .i_raddr(raddr), .o_rdata(h_b)
    );
    teg_ram #(.WIDTH(MOB_W), .DEPTH(DEPTH)) u_mobility (
        .i_clk(i_clk), .i_we(we_cmd), .i_waddr(in_addr), .i_wdata(m_wdata),
        .i_raddr(raddr), .o_rdata(m_rd)
    );

    // neighbour term, first stage: slope excess and minimum mobility
    logic signed [HEIGHT_W:0] d, ex;
    logic [HEIGHT_W-1:0] mag;
    logic [MOB_W-1:0]    m_min;
    logic                term_ok;
    always_comb begin
        d       = $signed({1'b0, h_rd}) - $signed({1'b0, r_ch});
        mag     = d[HEIGHT_W] ? HEIGHT_W'(-d) : d[HEIGHT_W-1:0];
        ex      = $signed({1'b0, mag}) - $signed({1'b0, r_talus});
        m_min   = (r_cm < m_rd) ? r_cm : m_rd;
        term_ok = r_rvalid && (r_rtag != 4'd0) && cell_in
                  && !ex[HEIGHT_W] && (ex != '0);
    end

    // round to nearest, ties up, then saturate
    logic signed [ACC_W-1:0] acc_rnd;
    logic [ACC_W-FRAC_BITS-1:0] rnd;
    always_comb begin
        acc_rnd = r_acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
        rnd     = acc_rnd[ACC_W-1:FRAC_BITS];
        if (r_acc <= 0) begin
            h_new = '0;
        end else if (rnd > (ACC_W-FRAC_BITS)'(HEIGHT_MAX)) begin
            h_new = HEIGHT_MAX;
        end else begin
            h_new = rnd[HEIGHT_W-1:0];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rtag  <= r_phase;
        r_rbank <= r_bank;
        if (r_rvalid && (r_rtag == 4'd0)) begin
            r_ch  <= h_rd;
            r_cm  <= m_rd;
            r_acc <= $signed({{(ACC_W-HEIGHT_W-FRAC_BITS){1'b0}}, h_rd, {FRAC_BITS{1'b0}}});
        end else if (r_v2) begin
            r_acc <= r_neg2 ? r_acc - $signed({{(ACC_W-PROD2_W){1'b0}}, r_p2})
                            : r_acc + $signed({{(ACC_W-PROD2_W){1'b0}}, r_p2});
        end
        r_p1   <= PROD1_W'(ex[HEIGHT_W-1:0] * rate_c);
        r_neg1 <= d[HEIGHT_W];
        r_m1   <= m_min;
        r_p2   <= PROD2_W'(r_p1 * r_m1);
        r_neg2 <= r_neg1;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 7'd64;
            r_grid_height <= 7'd64;
            r_sweep_count <= 16'd1;
            r_rate        <= RATE_ONE;
            r_talus       <= '0;
            r_wrap        <= 1'b0;
            r_state       <= S_IDLE;
            r_bank        <= 1'b0;
            r_sweeps_left <= '0;
            r_phase       <= '0;
            r_x           <= '0;
            r_y           <= '0;
            r_rd_inside   <= 1'b0;
            r_rvalid      <= 1'b0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_kind    <= CMD_WRITE;
            r_out_height  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[6:0];
                    CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[6:0];
                    CFG_SWEEP_COUNT: r_sweep_count <= i_cfg_data[15:0];
                    CFG_RATE:        r_rate        <= i_cfg_data[RATE_W-1:0];
                    CFG_TALUS:       r_talus       <= i_cfg_data;
                    CFG_WRAP:        r_wrap        <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // drop the reply once transferred
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            r_rvalid <= (r_state == S_SWEEP) && (r_phase <= 4'd4);
            r_v1     <= term_ok;
            r_v2     <= r_v1;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_cmd)
                            CMD_WRITE: begin
                                r_out_valid  <= 1'b1;
                                r_out_kind   <= CMD_WRITE;
                                r_out_height <= '0;
                            end
                            CMD_RUN: begin
                                if ((rate_c != '0) && (r_sweep_count != '0)) begin
                                    r_state       <= S_SWEEP;
                                    r_sweeps_left <= r_sweep_count;
                                    r_phase       <= '0;
                                    r_x           <= '0;
                                    r_y           <= '0;
                                end else begin
                                    r_out_valid  <= 1'b1;
                                    r_out_kind   <= CMD_RUN;
                                    r_out_height <= '0;
                                end
                            end
                            CMD_READ: begin
                                r_state     <= S_READ;
                                r_rd_inside <= in_inside;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    r_out_valid  <= 1'b1;
                    r_out_kind   <= CMD_READ;
                    r_out_height <= r_rd_inside ? (r_bank ? h_b : h_a) : '0;
                    r_state      <= S_IDLE;
                end
                S_SWEEP: begin
                    if (r_phase != PH_LAST) begin
                        r_phase <= r_phase + 1'b1;
                    end else begin
                        // advance to the next cell, or close the sweep
                        r_phase <= '0;
                        if (32'(r_x) != MAX_COLS - 1) begin
                            r_x <= r_x + 1'b1;
                        end else begin
                            r_x <= '0;
                            if (32'(r_y) != MAX_ROWS - 1) begin
                                r_y <= r_y + 1'b1;
                            end else begin
                                r_y           <= '0;
                                r_bank        <= !r_bank;
                                r_sweeps_left <= r_sweeps_left - 1'b1;
                                if (r_sweeps_left == 16'd1) begin
                                    r_state      <= S_IDLE;
                                    r_out_valid  <= 1'b1;
                                    r_out_kind   <= CMD_RUN;
                                    r_out_height <= '0;
                                end
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_reply_kind = r_out_kind;
    assign o_height_out = r_out_height;

    // only read replies carry a height
    a_height_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_reply_kind != CMD_READ)) |-> (o_height_out == '0))
        else $error("height on a non-read reply");

    // no command is taken while a sweep or read is in work
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("command taken while busy");

    // sweep writes land only in the bank not being read
    a_sweep_dst_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we_sweep |-> ((we_a == r_bank) && (we_b == !r_bank)))
        else $error("sweep writes the source bank");

    // a reply never overwrites one still held
    a_no_reply_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_reply_kind)))
        else $error("held reply lost");
endmodule
`default_nettype wire
